// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Sizes, entry layout, operation codes, sequencer states and the control
// and status words passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH         = 16;
	localparam int TAG_BITS      = 8;
	localparam int PRIORITY_BITS = 8;
	localparam int IDX_W         = $clog2(DEPTH);
	localparam int CNT_W         = $clog2(DEPTH + 1);

	// operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef struct packed {
		logic [TAG_BITS-1:0]      tag;
		logic [PRIORITY_BITS-1:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_REM_RD,
		ST_REM_CAP,
		ST_FRONT_RD,
		ST_FRONT_CAP,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ADDR_IDX,
		ADDR_IDX_M1,
		ADDR_ZERO
	} addr_sel_t;

	typedef enum logic {
		WD_RDATA,
		WD_NEW
	} wdata_sel_t;

	// results of the shared compare and index unit
	typedef struct packed {
		logic [IDX_W-1:0] idx_m1;
		logic [IDX_W-1:0] idx_p1;
		logic             lower;
		logic             at_one;
		logic             at_zero;
		logic             last;
	} step_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic accept;
		logic func;
		logic full;
		logic empty;
		logic out_free;
		step_t step;
	} status_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic       req_ready;
		logic       ram_re;
		logic       ram_we;
		addr_sel_t  addr_sel;
		wdata_sel_t wdata_sel;
		logic       idx_dec;
		logic       idx_inc;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       cap_removed;
		logic       cap_front;
		logic       load_out;
	} ctrl_t;

endpackage

// ----- rtl/spq_if.sv -----
// ----------------------------------------------------------------------------
// spq_if: request and response channels of the stable priority queue
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic [TAG_BITS-1:0]      entry_tag;
	logic [PRIORITY_BITS-1:0] entry_priority;

	modport source (output valid, func, entry_tag, entry_priority, input ready);
	modport sink   (input valid, func, entry_tag, entry_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     removed_valid;
	logic [TAG_BITS-1:0]      removed_tag;
	logic [PRIORITY_BITS-1:0] removed_priority;
	logic                     queue_empty;
	logic [TAG_BITS-1:0]      front_tag;
	logic [PRIORITY_BITS-1:0] front_priority;
	logic [CNT_W-1:0]         entry_count;
	logic                     insert_dropped;

	modport source (output valid, removed_valid, removed_tag, removed_priority,
		queue_empty, front_tag, front_priority, entry_count, insert_dropped,
		input ready);
	modport sink   (input valid, removed_valid, removed_tag, removed_priority,
		queue_empty, front_tag, front_priority, entry_count, insert_dropped,
		output ready);
endinterface

// ----- rtl/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue with stable ordering
// An insert takes longer the more entries it passes over and a remove the more
// entries are held; an insert on a full queue or a remove on an empty one
// goes straight to fetching the front. Words are handled one at a time, paced
// by the one-port-pair slot memory that is read and written once per entry moved.
// Reset: asynchronous, queue empty and idle; slot contents are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue import spq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	spq_req_if.sink      req,
	spq_rsp_if.source    rsp
);

	ctrl_t   ctrl;
	status_t status;
	state_t  state;
	step_t   step;

	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         idx_q;
	logic [TAG_BITS-1:0]      tag_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic                     rem_valid_q;
	entry_t                   removed_q;
	entry_t                   front_q;
	logic                     dropped_q;
	logic                     out_valid_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic [IDX_W-1:0]         ram_addr;
	entry_t                   ram_wdata;
	entry_t                   ram_rdata;
	logic [ENTRY_W-1:0]       ram_rdata_raw;

	assign accept = req.valid && req.ready;
	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;

	assign req.ready = ctrl.req_ready;

	// shared compare and index unit
	spq_step u_step (
		.idx      (idx_q),
		.count    (count_q),
		.rd_prio  (ram_rdata.prio),
		.new_prio (prio_q),
		.step     (step)
	);

	// collect status for the sequencer
	always_comb begin
		status.accept   = accept;
		status.func     = req.func;
		status.full     = full;
		status.empty    = empty;
		status.out_free = !out_valid_q || rsp.ready;
		status.step     = step;
	end

	spq_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.state  (state)
	);

	// select slot address and write word
	always_comb begin
		unique case (ctrl.addr_sel)
			ADDR_IDX:    ram_addr = idx_q;
			ADDR_IDX_M1: ram_addr = step.idx_m1;
			ADDR_ZERO:   ram_addr = '0;
			default:     ram_addr = '0;
		endcase
		unique case (ctrl.wdata_sel)
			WD_RDATA: ram_wdata = ram_rdata;
			WD_NEW:   ram_wdata = '{tag: tag_q, prio: prio_q};
			default:  ram_wdata = ram_rdata;
		endcase
	end

	assign ram_rdata = entry_t'(ram_rdata_raw);

	spq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ctrl.ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ctrl.ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata_raw)
	);

	// hold count and slot index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (ctrl.cnt_inc)      count_q <= count_q + CNT_W'(1);
			else if (ctrl.cnt_dec) count_q <= count_q - CNT_W'(1);

			if (accept) begin
				// insert walks back from the tail, remove walks forward from the head
				if (req.func == FUNC_INSERT) idx_q <= count_q[IDX_W-1:0];
				else                         idx_q <= '0;
			end else if (ctrl.idx_dec) begin
				idx_q <= step.idx_m1;
			end else if (ctrl.idx_inc) begin
				idx_q <= step.idx_p1;
			end
		end
	end

	// latch the incoming word and collect result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q       <= req.entry_tag;
			prio_q      <= req.entry_priority;
			rem_valid_q <= 1'b0;
			removed_q   <= '0;
			dropped_q   <= (req.func == FUNC_INSERT) && full;
		end
		if (ctrl.cap_removed) begin
			rem_valid_q <= 1'b1;
			removed_q   <= ram_rdata;
		end
		if (ctrl.cap_front) begin
			front_q <= empty ? '0 : ram_rdata;
		end
	end

	// response register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// response register: payload
	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			rsp.removed_valid    <= rem_valid_q;
			rsp.removed_tag      <= removed_q.tag;
			rsp.removed_priority <= removed_q.prio;
			rsp.queue_empty      <= empty;
			rsp.front_tag        <= front_q.tag;
			rsp.front_priority   <= front_q.prio;
			rsp.entry_count      <= count_q;
			rsp.insert_dropped   <= dropped_q;
		end
	end

	assign rsp.valid = out_valid_q;

	// the count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// an insert into a full queue is refused and leaves the count alone
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func == FUNC_INSERT && full) |=> (dropped_q && full))
		else $error("insert on full queue not dropped");

	// the slot memory is never read and written in the same cycle
	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ram_we && ctrl.ram_re))
		else $error("slot memory read and write collide");

	// a word never reports both a removal and a dropped insert
	a_rsp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.removed_valid && rsp.insert_dropped))
		else $error("removal and drop in one word");

	// empty flag agrees with the count in every word
	a_rsp_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.queue_empty == (rsp.entry_count == '0)))
		else $error("empty flag disagrees with count");

	// no word is accepted while the sequencer is busy
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (state == ST_IDLE))
		else $error("ready outside idle");

endmodule

// ----- rtl/spq_ram.sv -----
// ----------------------------------------------------------------------------
// spq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/spq_step.sv -----
// ----------------------------------------------------------------------------
// spq_step: shared compare and index unit
// Compares a stored priority against the new one and steps the slot index
// up or down; used by every iteration of insert and remove.
// ----------------------------------------------------------------------------
module spq_step import spq_pkg::*; (
	input  logic [IDX_W-1:0]         idx,
	input  logic [CNT_W-1:0]         count,
	input  logic [PRIORITY_BITS-1:0] rd_prio,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	output step_t                    step
);

	logic [CNT_W-1:0] idx_ext;
	logic [CNT_W-1:0] idx_next;

	assign idx_ext  = CNT_W'(idx);
	assign idx_next = idx_ext + CNT_W'(1);

	// step the index and compare
	always_comb begin
		step.idx_m1  = idx - IDX_W'(1);
		step.idx_p1  = idx_next[IDX_W-1:0];
		// strictly lower priority moves back, equal keeps its place
		step.lower   = rd_prio < new_prio;
		step.at_one  = idx == IDX_W'(1);
		step.at_zero = idx == '0;
		step.last    = idx_next == count;
	end

endmodule

// ----- rtl/spq_fsm.sv -----
// ----------------------------------------------------------------------------
// spq_fsm: sequencer of the stable priority queue
// Walks the slot memory one entry per read/write pair for insert and
// remove, then fetches the new front and hands the result word over.
// ----------------------------------------------------------------------------
module spq_fsm import spq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl,
	output state_t  state
);

	state_t state_q;
	state_t state_next;

	assign state = state_q;

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.accept) begin
					if (status.func == FUNC_INSERT) begin
						if (status.full)       state_next = ST_FRONT_RD;
						else if (status.empty) state_next = ST_INS_PUT;
						else                   state_next = ST_INS_RD;
					end else begin
						if (status.empty) state_next = ST_FRONT_RD;
						else              state_next = ST_REM_RD;
					end
				end
			end
			ST_INS_RD: state_next = ST_INS_CMP;
			ST_INS_CMP: begin
				if (status.step.lower && !status.step.at_one) state_next = ST_INS_RD;
				else                                          state_next = ST_INS_PUT;
			end
			ST_INS_PUT: state_next = ST_FRONT_RD;
			ST_REM_RD: state_next = ST_REM_CAP;
			ST_REM_CAP: begin
				if (status.step.last) state_next = ST_FRONT_RD;
				else                  state_next = ST_REM_RD;
			end
			ST_FRONT_RD: state_next = ST_FRONT_CAP;
			ST_FRONT_CAP: state_next = ST_DONE;
			ST_DONE: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// drive datapath commands
	always_comb begin
		ctrl = '0;
		ctrl.addr_sel  = ADDR_IDX;
		ctrl.wdata_sel = WD_RDATA;
		unique case (state_q)
			ST_IDLE: ctrl.req_ready = 1'b1;
			ST_INS_RD: begin
				ctrl.ram_re   = 1'b1;
				ctrl.addr_sel = ADDR_IDX_M1;
			end
			ST_INS_CMP: begin
				// move the lower entry one slot back
				if (status.step.lower) begin
					ctrl.ram_we  = 1'b1;
					ctrl.idx_dec = 1'b1;
				end
			end
			ST_INS_PUT: begin
				ctrl.ram_we    = 1'b1;
				ctrl.wdata_sel = WD_NEW;
				ctrl.cnt_inc   = 1'b1;
			end
			ST_REM_RD: ctrl.ram_re = 1'b1;
			ST_REM_CAP: begin
				// slot zero leaves, every later one moves forward
				if (status.step.at_zero) begin
					ctrl.cap_removed = 1'b1;
				end else begin
					ctrl.ram_we   = 1'b1;
					ctrl.addr_sel = ADDR_IDX_M1;
				end
				if (status.step.last) ctrl.cnt_dec = 1'b1;
				else                  ctrl.idx_inc = 1'b1;
			end
			ST_FRONT_RD: begin
				ctrl.ram_re   = 1'b1;
				ctrl.addr_sel = ADDR_ZERO;
			end
			ST_FRONT_CAP: ctrl.cap_front = 1'b1;
			ST_DONE: ctrl.load_out = status.out_free;
			default: ctrl = '0;
		endcase
	end

endmodule
